>>> rtl/core/mrfs_pkg.sv
// Package with the payload types, configuration types and codes of the motor fault supervisor.
`timescale 1ns / 1ps

package mrfs_pkg;

	// Configuration register indexes.
	localparam int CfgIdxWidth = 2;
	localparam logic [CfgIdxWidth-1:0] CFG_SENSOR_THRESHOLD = 2'd0;
	localparam logic [CfgIdxWidth-1:0] CFG_REQUIRED_MASK    = 2'd1;
	localparam logic [CfgIdxWidth-1:0] CFG_UV_PROTECT       = 2'd2;
	localparam logic [CfgIdxWidth-1:0] CFG_STATS_ENABLE     = 2'd3;
	localparam int CfgDataWidth = 16;

	// Reset values of the configuration registers.
	localparam logic [7:0]  SENSOR_THRESHOLD_RST = 8'd3;
	localparam logic [15:0] REQUIRED_MASK_RST    = 16'd127;

	// System mode codes.
	localparam logic [1:0] MODE_INIT    = 2'd0;
	localparam logic [1:0] MODE_RUNNING = 2'd1;
	localparam logic [1:0] MODE_FAULT   = 2'd2;

	// Link mode codes.
	localparam logic [1:0] LINK_IDLE   = 2'd0;
	localparam logic [1:0] LINK_ACTIVE = 2'd1;
	localparam logic [1:0] LINK_ERROR  = 2'd2;

	// Init verdict codes.
	localparam logic [1:0] VERDICT_NONE   = 2'd0;
	localparam logic [1:0] VERDICT_OK     = 2'd1;
	localparam logic [1:0] VERDICT_FAILED = 2'd2;

	// Fault codes.
	localparam logic [2:0] CODE_NONE         = 3'd0;
	localparam logic [2:0] CODE_ADC          = 3'd1;
	localparam logic [2:0] CODE_ENCODER      = 3'd2;
	localparam logic [2:0] CODE_UNDERVOLTAGE = 3'd3;
	localparam logic [2:0] CODE_PARAM        = 3'd4;
	localparam logic [2:0] CODE_FRAME        = 3'd5;
	localparam logic [2:0] CODE_INIT         = 3'd6;

	// Command outcome codes; any other value counts as a command error.
	localparam logic [1:0] OUTCOME_OK        = 2'd0;
	localparam logic [1:0] OUTCOME_PARAM_ERR = 2'd1;

	typedef struct packed {
		logic [15:0] check_pass_bits;
		logic [15:0] check_fail_bits;
		logic        sensor_updated;
		logic        adc_ok;
		logic        encoder_ok;
		logic        loop_skipped;
		logic        undervoltage;
		logic        evaluate_checks;
		logic        cmd_done;
		logic [1:0]  cmd_outcome;
		logic        frame_error;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  system_mode;
		logic [1:0]  link_mode;
		logic [1:0]  init_verdict;
		logic [2:0]  fault_code;
		logic [15:0] missing_bits;
		logic [7:0]  sensor_bad_run;
		logic [15:0] skip_total;
		logic [15:0] param_error_total;
		logic [15:0] protocol_error_total;
		logic        last_cmd_ok;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  sensor_fault_threshold;
		logic [15:0] required_check_mask;
		logic        undervoltage_protect_enable;
		logic        stats_enable;
	} cfg_t;

endpackage

>>> rtl/core/mrfs_cfg_regs.sv
// Configuration register file of the motor fault supervisor.
`timescale 1ns / 1ps

module mrfs_cfg_regs import mrfs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0] cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// The register file always takes a write beat.
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_fault_threshold      <= SENSOR_THRESHOLD_RST;
			cfg_q.required_check_mask         <= REQUIRED_MASK_RST;
			cfg_q.undervoltage_protect_enable <= 1'b1;
			cfg_q.stats_enable                <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SENSOR_THRESHOLD: cfg_q.sensor_fault_threshold <= cfg_data[7:0];
				CFG_REQUIRED_MASK:    cfg_q.required_check_mask <= cfg_data;
				CFG_UV_PROTECT:       cfg_q.undervoltage_protect_enable <= cfg_data[0];
				CFG_STATS_ENABLE:     cfg_q.stats_enable <= cfg_data[0];
			endcase
		end
	end

endmodule

>>> rtl/core/mrfs_in_stage.sv
// Input register stage of the motor fault supervisor.
`timescale 1ns / 1ps

module mrfs_in_stage import mrfs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  logic     advance,
	output logic     valid_s1,
	output in_item_t item_s1
);

	logic accept;

	// The stage takes a new beat when it is empty or drains in this cycle.
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Occupancy of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

endmodule

>>> rtl/core/mrfs_state.sv
// Supervisor state registers and their single-pass update logic.
`timescale 1ns / 1ps

module mrfs_state import mrfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  in_item_t  item_s1,
	input  cfg_t      cfg,
	output out_item_t result
);

	logic [1:0]  system_mode_q;
	logic [1:0]  link_mode_q;
	logic [1:0]  init_verdict_q;
	logic [2:0]  fault_code_q;
	logic [15:0] checks_seen_q;
	logic [15:0] checks_failed_q;
	logic [7:0]  sensor_bad_q;
	logic [15:0] skip_q;
	logic [15:0] param_err_q;
	logic [15:0] proto_err_q;
	logic        cmd_ok_q;

	logic [1:0]  system_mode_d;
	logic [1:0]  link_mode_d;
	logic [1:0]  init_verdict_d;
	logic [2:0]  fault_code_d;
	logic [15:0] checks_seen_d;
	logic [15:0] checks_failed_d;
	logic [7:0]  sensor_bad_d;
	logic [15:0] skip_d;
	logic [15:0] param_err_d;
	logic [15:0] proto_err_d;
	logic        cmd_ok_d;

	logic        sensor_bad;
	logic        uv_trip;
	logic [1:0]  skip_events;
	logic [15:0] missing;
	logic        param_bump;
	logic        proto_cmd_bump;
	logic        proto_frame_bump;

	// Next state for one item: sensor, undervoltage and init checks, then command result, frame error and statistics.
	always_comb begin
		checks_seen_d   = checks_seen_q | item_s1.check_pass_bits | item_s1.check_fail_bits;
		checks_failed_d = checks_failed_q | item_s1.check_fail_bits;
		missing         = cfg.required_check_mask & ~checks_seen_d;

		system_mode_d  = system_mode_q;
		link_mode_d    = link_mode_q;
		init_verdict_d = init_verdict_q;
		fault_code_d   = fault_code_q;
		sensor_bad_d   = sensor_bad_q;
		cmd_ok_d       = cmd_ok_q;

		sensor_bad = item_s1.sensor_updated && !(item_s1.adc_ok && item_s1.encoder_ok);
		uv_trip    = item_s1.undervoltage && cfg.undervoltage_protect_enable;

		// Sensor validity: a good sample clears the run, a bad one extends it.
		if (item_s1.sensor_updated) begin
			if (!sensor_bad) begin
				sensor_bad_d = '0;
				if (system_mode_q != MODE_FAULT) begin
					fault_code_d = CODE_NONE;
				end
			end else begin
				if (sensor_bad_q != 8'hFF) begin
					sensor_bad_d = sensor_bad_q + 8'd1;
				end
				fault_code_d = item_s1.adc_ok ? CODE_ENCODER : CODE_ADC;
				if (sensor_bad_d >= cfg.sensor_fault_threshold) begin
					system_mode_d = MODE_FAULT;
				end
			end
		end

		// Undervoltage protection.
		if (uv_trip) begin
			system_mode_d = MODE_FAULT;
			fault_code_d  = CODE_UNDERVOLTAGE;
		end

		// Evaluation of the collected init checks.
		if (item_s1.evaluate_checks) begin
			if (checks_seen_d == '0) begin
				init_verdict_d = VERDICT_NONE;
				system_mode_d  = MODE_FAULT;
				fault_code_d   = CODE_INIT;
			end else if (checks_failed_d == '0 && missing == '0) begin
				init_verdict_d = VERDICT_OK;
				system_mode_d  = MODE_RUNNING;
				fault_code_d   = CODE_NONE;
			end else begin
				init_verdict_d = VERDICT_FAILED;
				system_mode_d  = MODE_FAULT;
				fault_code_d   = CODE_INIT;
			end
		end

		// Command result.
		param_bump     = 1'b0;
		proto_cmd_bump = 1'b0;
		if (item_s1.cmd_done) begin
			if (item_s1.cmd_outcome == OUTCOME_OK) begin
				cmd_ok_d    = 1'b1;
				link_mode_d = LINK_ACTIVE;
			end else begin
				cmd_ok_d    = 1'b0;
				link_mode_d = LINK_ERROR;
				if (item_s1.cmd_outcome == OUTCOME_PARAM_ERR) begin
					param_bump   = 1'b1;
					fault_code_d = CODE_PARAM;
				end else begin
					proto_cmd_bump = 1'b1;
					fault_code_d   = CODE_FRAME;
				end
			end
		end

		// Frame error.
		proto_frame_bump = item_s1.frame_error;
		if (item_s1.frame_error) begin
			fault_code_d = CODE_FRAME;
		end

		// Statistics counters wrap and hold while statistics are off.
		skip_events = {1'b0, sensor_bad} + {1'b0, item_s1.loop_skipped} + {1'b0, uv_trip};
		skip_d      = skip_q;
		param_err_d = param_err_q;
		proto_err_d = proto_err_q;
		if (cfg.stats_enable) begin
			skip_d      = skip_q + {14'd0, skip_events};
			param_err_d = param_err_q + {15'd0, param_bump};
			proto_err_d = proto_err_q + {15'd0, proto_cmd_bump}
				+ {15'd0, proto_frame_bump};
		end
	end

	// The result shows the state after the item.
	always_comb begin
		result.system_mode          = system_mode_d;
		result.link_mode            = link_mode_d;
		result.init_verdict         = init_verdict_d;
		result.fault_code           = fault_code_d;
		result.missing_bits         = missing;
		result.sensor_bad_run       = sensor_bad_d;
		result.skip_total           = skip_d;
		result.param_error_total    = param_err_d;
		result.protocol_error_total = proto_err_d;
		result.last_cmd_ok          = cmd_ok_d;
	end

	// State registers advance once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			system_mode_q   <= MODE_INIT;
			link_mode_q     <= LINK_IDLE;
			init_verdict_q  <= VERDICT_NONE;
			fault_code_q    <= CODE_NONE;
			checks_seen_q   <= '0;
			checks_failed_q <= '0;
			sensor_bad_q    <= '0;
			skip_q          <= '0;
			param_err_q     <= '0;
			proto_err_q     <= '0;
			cmd_ok_q        <= 1'b0;
		end else if (advance) begin
			system_mode_q   <= system_mode_d;
			link_mode_q     <= link_mode_d;
			init_verdict_q  <= init_verdict_d;
			fault_code_q    <= fault_code_d;
			checks_seen_q   <= checks_seen_d;
			checks_failed_q <= checks_failed_d;
			sensor_bad_q    <= sensor_bad_d;
			skip_q          <= skip_d;
			param_err_q     <= param_err_d;
			proto_err_q     <= proto_err_d;
			cmd_ok_q        <= cmd_ok_d;
		end
	end

endmodule

>>> rtl/core/mrfs_out_stage.sv
// Result register stage of the motor fault supervisor.
`timescale 1ns / 1ps

module mrfs_out_stage import mrfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  out_item_t result,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	output logic      ready
);

	logic      out_valid_q;
	out_item_t out_data_q;

	// The register takes a result when it is empty or its beat leaves now.
	assign ready     = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Occupancy of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

endmodule

>>> rtl/core/motor_runtime_fault_supervisor_core.sv
// Top level of the motor run-state fault supervisor.
`timescale 1ns / 1ps

// The supervisor takes one status beat per clock while no stalled result holds it, and returns one
// result beat per input beat, holding the system, link and init state after that beat together with
// the fault code, the missing init checks and the statistics counters. A beat is registered in the
// input stage, passes the state update logic and is registered in the result register and the
// state registers at once; the sustained rate is one beat per cycle while out_stall is low, and
// the state register update, on which every beat depends, sets that rate. A stalled result holds the
// input stage, which in turn raises in_stall. Configuration writes are taken at any time with
// cfg_ready high and belong only in idle periods.
module motor_runtime_fault_supervisor_core import mrfs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  in_item_t                in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output out_item_t               out_data,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CfgIdxWidth-1:0]  cfg_index,
	input  logic [CfgDataWidth-1:0] cfg_data
);

	cfg_t      cfg;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;
	logic      out_ready;
	out_item_t result;

	// An item moves from the input stage into the state and result registers together.
	assign advance = valid_s1 && out_ready;

	mrfs_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mrfs_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mrfs_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	mrfs_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.result    (result),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.ready     (out_ready)
	);

endmodule

>>> bench/tb_motor_runtime_fault_supervisor_core.sv
// Self-checking testbench for the motor run-state fault supervisor core.
`timescale 1ns / 1ps

module tb_motor_runtime_fault_supervisor_core;
	import mrfs_pkg::*;

	// Command outcomes that the package leaves unnamed.
	localparam logic [1:0] OUTCOME_CMD_ERR   = 2'd2;
	localparam logic [1:0] OUTCOME_UNDEFINED = 2'd3;

	localparam int RX_HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES  = 6;
	localparam int SATURATE_BEATS = 270;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	in_item_t                in_data;
	logic                    out_valid;
	logic                    out_stall;
	out_item_t               out_data;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CfgIdxWidth-1:0]  cfg_index;
	logic [CfgDataWidth-1:0] cfg_data;

	motor_runtime_fault_supervisor_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// One row of the directed stimulus: a register write or an input beat.
	typedef struct {
		bit                     is_cfg;
		logic [CfgIdxWidth-1:0] idx;
		logic [15:0]            val;
		in_item_t               beat;
		bit                     typed;
		out_item_t              want;
	} stim_row_t;

	// Hand-written expectation travelling with an offered beat.
	typedef struct {
		bit        typed;
		out_item_t want;
	} beat_tag_t;

	beat_tag_t offered_tag_q[$];
	out_item_t pending_status_q[$];
	int        mismatch_count = 0;
	int        tx_idle_pct = 0;
	int        rx_stall_pct = 0;
	logic      hold_toggle;

	// Mirror of the supervisor state and its registers.
	logic [1:0]  st_mode    = MODE_INIT;
	logic [1:0]  st_link    = LINK_IDLE;
	logic [1:0]  st_verdict = VERDICT_NONE;
	logic [2:0]  st_code    = CODE_NONE;
	logic [15:0] seen_mask  = '0;
	logic [15:0] failed_mask = '0;
	logic [7:0]  bad_run    = '0;
	logic [15:0] skip_ctr   = '0;
	logic [15:0] param_ctr  = '0;
	logic [15:0] proto_ctr  = '0;
	logic        cmd_ok     = 1'b0;
	logic [7:0]  thr        = SENSOR_THRESHOLD_RST;
	logic [15:0] req_mask   = REQUIRED_MASK_RST;
	logic        uv_en      = 1'b1;
	logic        stats_en   = 1'b1;

	// Clock with a 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// Advances the mirrored state by one beat and returns the status it leaves.
	function automatic out_item_t supervise_step(input in_item_t b);
		out_item_t r;
		seen_mask = seen_mask | b.check_pass_bits | b.check_fail_bits;
		failed_mask = failed_mask | b.check_fail_bits;
		if (b.sensor_updated) begin
			if (b.adc_ok && b.encoder_ok) begin
				bad_run = '0;
				if (st_mode != MODE_FAULT) begin
					st_code = CODE_NONE;
				end
			end else begin
				skip_ctr = skip_ctr + 16'(stats_en);
				if (bad_run != 8'hFF) begin
					bad_run = bad_run + 8'd1;
				end
				st_code = b.adc_ok ? CODE_ENCODER : CODE_ADC;
				if (bad_run >= thr) begin
					st_mode = MODE_FAULT;
				end
			end
		end
		if (b.loop_skipped) begin
			skip_ctr = skip_ctr + 16'(stats_en);
		end
		if (b.undervoltage && uv_en) begin
			st_mode = MODE_FAULT;
			st_code = CODE_UNDERVOLTAGE;
			skip_ctr = skip_ctr + 16'(stats_en);
		end
		// Init evaluation over everything collected so far.
		if (b.evaluate_checks) begin
			if (seen_mask == '0) begin
				st_verdict = VERDICT_NONE;
				st_mode = MODE_FAULT;
				st_code = CODE_INIT;
			end else if (failed_mask == '0 && (req_mask & ~seen_mask) == '0) begin
				st_verdict = VERDICT_OK;
				st_mode = MODE_RUNNING;
				st_code = CODE_NONE;
			end else begin
				st_verdict = VERDICT_FAILED;
				st_mode = MODE_FAULT;
				st_code = CODE_INIT;
			end
		end
		if (b.cmd_done) begin
			if (b.cmd_outcome == OUTCOME_OK) begin
				cmd_ok = 1'b1;
				st_link = LINK_ACTIVE;
			end else begin
				cmd_ok = 1'b0;
				st_link = LINK_ERROR;
				if (b.cmd_outcome == OUTCOME_PARAM_ERR) begin
					param_ctr = param_ctr + 16'(stats_en);
					st_code = CODE_PARAM;
				end else begin
					proto_ctr = proto_ctr + 16'(stats_en);
					st_code = CODE_FRAME;
				end
			end
		end
		if (b.frame_error) begin
			proto_ctr = proto_ctr + 16'(stats_en);
			st_code = CODE_FRAME;
		end
		r.system_mode = st_mode;
		r.link_mode = st_link;
		r.init_verdict = st_verdict;
		r.fault_code = st_code;
		r.missing_bits = req_mask & ~seen_mask;
		r.sensor_bad_run = bad_run;
		r.skip_total = skip_ctr;
		r.param_error_total = param_ctr;
		r.protocol_error_total = proto_ctr;
		r.last_cmd_ok = cmd_ok;
		return r;
	endfunction

	function automatic in_item_t mk_beat(input logic [15:0] pass, input logic [15:0] fail,
			input logic upd, input logic adc, input logic enc, input logic skip,
			input logic uv, input logic fin, input logic cmd, input logic [1:0] outcome,
			input logic frame);
		in_item_t b;
		b.check_pass_bits = pass;
		b.check_fail_bits = fail;
		b.sensor_updated = upd;
		b.adc_ok = adc;
		b.encoder_ok = enc;
		b.loop_skipped = skip;
		b.undervoltage = uv;
		b.evaluate_checks = fin;
		b.cmd_done = cmd;
		b.cmd_outcome = outcome;
		b.frame_error = frame;
		return b;
	endfunction

	function automatic out_item_t mk_status(input logic [1:0] mode, input logic [1:0] link,
			input logic [1:0] verdict, input logic [2:0] code, input logic [15:0] missing,
			input logic [7:0] bad, input logic [15:0] skips, input logic [15:0] perrs,
			input logic [15:0] proto, input logic ok);
		out_item_t r;
		r.system_mode = mode;
		r.link_mode = link;
		r.init_verdict = verdict;
		r.fault_code = code;
		r.missing_bits = missing;
		r.sensor_bad_run = bad;
		r.skip_total = skips;
		r.param_error_total = perrs;
		r.protocol_error_total = proto;
		r.last_cmd_ok = ok;
		return r;
	endfunction

	function automatic stim_row_t beat_row(input in_item_t b);
		stim_row_t row;
		row = '{default: '0};
		row.beat = b;
		return row;
	endfunction

	function automatic stim_row_t typed_row(input in_item_t b, input out_item_t want);
		stim_row_t row;
		row = beat_row(b);
		row.typed = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CfgIdxWidth-1:0] idx,
			input logic [15:0] val);
		stim_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = val;
		return row;
	endfunction

	// Random status beat; init failures only appear when asked for, since they stick.
	function automatic in_item_t random_beat(input bit with_failures);
		in_item_t b;
		int pick;
		b = '0;
		pick = $urandom_range(0, 9);
		if (pick == 9 && with_failures) begin
			b.check_pass_bits = 16'($urandom);
		end else if (pick >= 6) begin
			b.check_pass_bits = 16'h0001 << $urandom_range(0, 15);
		end
		if (with_failures && $urandom_range(0, 4) == 0) begin
			b.check_fail_bits = 16'($urandom);
		end
		b.sensor_updated = 1'($urandom_range(0, 1));
		b.adc_ok = ($urandom_range(0, 4) != 0);
		b.encoder_ok = ($urandom_range(0, 4) != 0);
		b.loop_skipped = ($urandom_range(0, 4) == 0);
		b.undervoltage = ($urandom_range(0, 19) == 0);
		b.evaluate_checks = ($urandom_range(0, 11) == 0);
		b.cmd_done = ($urandom_range(0, 9) < 3);
		b.cmd_outcome = 2'($urandom_range(0, 3));
		b.frame_error = ($urandom_range(0, 19) == 0);
		return b;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	task automatic check_status(input out_item_t want, input out_item_t got);
		check_field("system_mode", want.system_mode, got.system_mode);
		check_field("link_mode", want.link_mode, got.link_mode);
		check_field("init_verdict", want.init_verdict, got.init_verdict);
		check_field("fault_code", want.fault_code, got.fault_code);
		check_field("missing_bits", want.missing_bits, got.missing_bits);
		check_field("sensor_bad_run", want.sensor_bad_run, got.sensor_bad_run);
		check_field("skip_total", want.skip_total, got.skip_total);
		check_field("param_error_total", want.param_error_total, got.param_error_total);
		check_field("protocol_error_total", want.protocol_error_total,
			got.protocol_error_total);
		check_field("last_cmd_ok", want.last_cmd_ok, got.last_cmd_ok);
	endtask

	// Receiver: random stalls, plus a long hold-off whenever hold_toggle flips.
	int   hold_left;
	logic hold_seen;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else if (hold_seen != hold_toggle) begin
			hold_seen <= hold_toggle;
			hold_left <= RX_HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
		end
	end

	// Predicts on every accepted input beat and checks every accepted result beat.
	always @(posedge clk) begin : status_monitor
		out_item_t predicted;
		beat_tag_t tag;
		out_item_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predicted = supervise_step(in_data);
				tag = offered_tag_q.pop_front();
				pending_status_q.push_back(tag.typed ? tag.want : predicted);
			end
			if (out_valid && !out_stall) begin
				if (pending_status_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: result beat with no expectation, expected none, got %h",
						$time, out_data);
				end else begin
					want = pending_status_q.pop_front();
					check_status(want, out_data);
				end
			end
		end
	end

	// Offers one beat after a random gap and returns once it is accepted.
	task automatic send_beat(input in_item_t b, input bit typed, input out_item_t want);
		beat_tag_t tag;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		tag.typed = typed;
		tag.want = want;
		offered_tag_q.push_back(tag);
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// Stops offering and waits for every expected result beat to come back.
	// The first edge lets the monitor record a beat accepted at the previous edge.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_status_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write, only ever issued with the block drained.
	task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [15:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SENSOR_THRESHOLD: thr = val[7:0];
			CFG_REQUIRED_MASK:    req_mask = val;
			CFG_UV_PROTECT:       uv_en = val[0];
			CFG_STATS_ENABLE:     stats_en = val[0];
			default: ;
		endcase
	endtask

	task automatic random_phase(input int beats, input bit with_failures);
		for (int i = 0; i < beats; i++) begin
			send_beat(random_beat(with_failures), 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		stim_row_t  stim_table[$];
		in_item_t   b;
		logic [15:0] rst_mask;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SENSOR_THRESHOLD;
		cfg_data = '0;
		hold_toggle = 1'b0;
		rst_mask = REQUIRED_MASK_RST;

		// Directed part, starting from the reset configuration.
		stim_table.push_back(typed_row(mk_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, OUTCOME_OK, 0),
			mk_status(MODE_INIT, LINK_IDLE, VERDICT_NONE, CODE_NONE, rst_mask, 0, 0, 0, 0, 0)));
		// Finalize before any check has been reported.
		stim_table.push_back(typed_row(mk_beat(0, 0, 0, 0, 0, 0, 0, 1, 0, OUTCOME_OK, 0),
			mk_status(MODE_FAULT, LINK_IDLE, VERDICT_NONE, CODE_INIT, rst_mask, 0, 0, 0, 0, 0)));
		// Frame error alone leaves the system mode untouched.
		stim_table.push_back(typed_row(mk_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, OUTCOME_OK, 1),
			mk_status(MODE_FAULT, LINK_IDLE, VERDICT_NONE, CODE_FRAME, rst_mask, 0, 0, 0, 1, 0)));
		// Every command outcome, the undefined one included.
		stim_table.push_back(typed_row(mk_beat(0, 0, 0, 0, 0, 0, 0, 0, 1, OUTCOME_OK, 0),
			mk_status(MODE_FAULT, LINK_ACTIVE, VERDICT_NONE, CODE_FRAME, rst_mask,
				0, 0, 0, 1, 1)));
		stim_table.push_back(typed_row(mk_beat(0, 0, 0, 0, 0, 0, 0, 0, 1, OUTCOME_PARAM_ERR, 0),
			mk_status(MODE_FAULT, LINK_ERROR, VERDICT_NONE, CODE_PARAM, rst_mask, 0, 0, 1, 1, 0)));
		stim_table.push_back(typed_row(mk_beat(0, 0, 0, 0, 0, 0, 0, 0, 1, OUTCOME_CMD_ERR, 0),
			mk_status(MODE_FAULT, LINK_ERROR, VERDICT_NONE, CODE_FRAME, rst_mask, 0, 0, 1, 2, 0)));
		stim_table.push_back(typed_row(mk_beat(0, 0, 0, 0, 0, 0, 0, 0, 1, OUTCOME_UNDEFINED, 0),
			mk_status(MODE_FAULT, LINK_ERROR, VERDICT_NONE, CODE_FRAME, rst_mask, 0, 0, 1, 3, 0)));
		// Finalize with required checks still missing, then with all of them seen.
		stim_table.push_back(typed_row(mk_beat(16'h0001, 0, 0, 0, 0, 0, 0, 1, 0, OUTCOME_OK, 0),
			mk_status(MODE_FAULT, LINK_ERROR, VERDICT_FAILED, CODE_INIT, rst_mask & ~16'h0001,
				0, 0, 1, 3, 0)));
		stim_table.push_back(typed_row(mk_beat(16'hFFFF, 0, 0, 0, 0, 0, 0, 1, 0, OUTCOME_OK, 0),
			mk_status(MODE_RUNNING, LINK_ERROR, VERDICT_OK, CODE_NONE, 16'h0000, 0, 0, 1, 3, 0)));
		// Invalid sensor samples up to the threshold, a valid one while in fault, a skipped loop, an undervoltage.
		stim_table.push_back(beat_row(mk_beat(0, 0, 1, 0, 0, 0, 0, 0, 0, OUTCOME_OK, 0)));
		stim_table.push_back(beat_row(mk_beat(0, 0, 1, 1, 0, 0, 0, 0, 0, OUTCOME_OK, 0)));
		stim_table.push_back(beat_row(mk_beat(0, 0, 1, 0, 1, 0, 0, 0, 0, OUTCOME_OK, 0)));
		stim_table.push_back(beat_row(mk_beat(0, 0, 1, 1, 1, 0, 0, 0, 0, OUTCOME_OK, 0)));
		stim_table.push_back(beat_row(mk_beat(0, 0, 0, 0, 0, 1, 0, 0, 0, OUTCOME_OK, 0)));
		stim_table.push_back(beat_row(mk_beat(0, 0, 0, 0, 0, 0, 1, 0, 0, OUTCOME_OK, 0)));
		// Zero threshold, undervoltage ignored, statistics frozen.
		stim_table.push_back(cfg_row(CFG_SENSOR_THRESHOLD, 16'd0));
		stim_table.push_back(cfg_row(CFG_UV_PROTECT, 16'd0));
		stim_table.push_back(cfg_row(CFG_STATS_ENABLE, 16'd0));
		stim_table.push_back(beat_row(mk_beat(0, 0, 1, 1, 1, 0, 0, 1, 0, OUTCOME_OK, 0)));
		stim_table.push_back(beat_row(mk_beat(0, 0, 1, 0, 0, 0, 0, 0, 0, OUTCOME_OK, 0)));
		stim_table.push_back(beat_row(mk_beat(0, 0, 0, 0, 0, 1, 1, 0, 1, OUTCOME_PARAM_ERR, 1)));
		// Extremes of the registers: top threshold, empty required mask, protection and statistics back on.
		stim_table.push_back(cfg_row(CFG_SENSOR_THRESHOLD, 16'd255));
		stim_table.push_back(cfg_row(CFG_REQUIRED_MASK, 16'h0000));
		stim_table.push_back(cfg_row(CFG_UV_PROTECT, 16'd1));
		stim_table.push_back(cfg_row(CFG_STATS_ENABLE, 16'd1));
		stim_table.push_back(beat_row(mk_beat(0, 0, 1, 0, 1, 1, 0, 1, 0, OUTCOME_OK, 0)));
		stim_table.push_back(beat_row(mk_beat(0, 0, 1, 1, 0, 0, 1, 0, 1, OUTCOME_OK, 1)));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed walk with both sides idling.
		tx_idle_pct = 22;
		rx_stall_pct = 48;
		foreach (stim_table[i]) begin
			if (stim_table[i].is_cfg) begin
				write_reg(stim_table[i].idx, stim_table[i].val);
			end else begin
				send_beat(stim_table[i].beat, stim_table[i].typed, stim_table[i].want);
			end
		end

		// Random phase: sender idles less than the receiver stalls.
		write_reg(CFG_SENSOR_THRESHOLD, 16'd1);
		write_reg(CFG_REQUIRED_MASK, 16'hFFFF);
		random_phase(70, 1'b0);

		// Random phase the other way round, with protection and statistics off.
		tx_idle_pct = 48;
		rx_stall_pct = 22;
		write_reg(CFG_SENSOR_THRESHOLD, 16'd255);
		write_reg(CFG_REQUIRED_MASK, 16'h0000);
		write_reg(CFG_UV_PROTECT, 16'd0);
		write_reg(CFG_STATS_ENABLE, 16'd0);
		random_phase(70, 1'b0);

		// Full rate; the receiver holds off first so the block backs up into in_stall.
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		write_reg(CFG_SENSOR_THRESHOLD, 16'd5);
		write_reg(CFG_REQUIRED_MASK, 16'($urandom));
		write_reg(CFG_UV_PROTECT, 16'd1);
		write_reg(CFG_STATS_ENABLE, 16'd1);
		hold_toggle <= ~hold_toggle;
		random_phase(80, 1'b1);

		// A long run of invalid samples saturates the run counter.
		write_reg(CFG_SENSOR_THRESHOLD, 16'd200);
		for (int i = 0; i < SATURATE_BEATS; i++) begin
			b = random_beat(1'b1);
			b.sensor_updated = 1'b1;
			if (b.adc_ok) begin
				b.encoder_ok = 1'b0;
			end
			b.loop_skipped = 1'b1;
			b.undervoltage = 1'b1;
			b.cmd_done = 1'b1;
			b.cmd_outcome = OUTCOME_PARAM_ERR;
			b.frame_error = 1'b1;
			send_beat(b, 1'b0, '0);
		end

		drain();
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/mrfs_pkg.sv
rtl/core/mrfs_cfg_regs.sv
rtl/core/mrfs_in_stage.sv
rtl/core/mrfs_state.sv
rtl/core/mrfs_out_stage.sv
rtl/core/motor_runtime_fault_supervisor_core.sv
bench/tb_motor_runtime_fault_supervisor_core.sv
